@@ rtl/gdpp_pkg.sv @@
package gdpp_pkg;

	localparam int unsigned LUMA_W   = 8;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CARRY_W  = 7;
	localparam int unsigned SLOT_W   = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W    = 8;

	// brightness - 16 is added to every sample
	localparam int signed   BRIGHT_OFFSET = 16;
	localparam int unsigned PIX_MAX       = 255;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BPP_LOG2   = 3'd0,
		CFG_BRIGHTNESS = 3'd1,
		CFG_DITHER_EN  = 3'd2,
		CFG_INVERT     = 3'd3,
		CFG_FIRST_HIGH = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        bpp_log2;
		logic signed [7:0] brightness;
		logic              dither_enable;
		logic              invert_output;
		logic              first_in_high_bits;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		bpp_log2:           2'd2,
		brightness:         8'sd0,
		dither_enable:      1'b0,
		invert_output:      1'b0,
		first_in_high_bits: 1'b0
	};

	// low (8 - bits per pixel) bits of a clamped sample, limited to 7 bits
	function automatic logic [CARRY_W-1:0] dither_mask(input logic [1:0] bpp_log2);
		logic [BYTE_W-1:0] m;
		begin
			m = 8'hFF >> (4'd1 << bpp_log2);
			dither_mask = m[CARRY_W-1:0];
		end
	endfunction

endpackage

@@ rtl/gray_dither_pixel_packer.sv @@
// Channel  Dir  Width  Contents
// s_*      in   8 + 1  s_tdata: luma[7:0]; s_tuser: frame_start
// m_*      out  8      m_tdata: packed_byte[7:0]
// cfg_*    in   3 + 8  register index, write data (no read-back)
//
// One word per clock sustained. A word is held in the input register, then the
// add, clamp, shift and merge into the partial byte run combinationally and
// finished bytes land in the output register.
// The input register only stalls when its word completes a byte while the
// output register still holds an untaken byte; words that only fill a slot
// pass through regardless of m_tready.
// arst_n clears config to defaults, carry to 7, packing state to slot 0.
module gray_dither_pixel_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // luma[7:0]
	input  logic [0:0]                    s_tuser,   // frame_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // packed_byte[7:0]
	input  logic                          cfg_we,
	input  logic [gdpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gdpp_pkg::CFG_W-1:0]    cfg_data
);

	// configuration registers
	gdpp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= gdpp_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gdpp_pkg::CFG_BPP_LOG2:   cfg_q.bpp_log2           <= cfg_data[1:0];
				gdpp_pkg::CFG_BRIGHTNESS: cfg_q.brightness         <= $signed(cfg_data);
				gdpp_pkg::CFG_DITHER_EN:  cfg_q.dither_enable      <= cfg_data[0];
				gdpp_pkg::CFG_INVERT:     cfg_q.invert_output      <= cfg_data[0];
				gdpp_pkg::CFG_FIRST_HIGH: cfg_q.first_in_high_bits <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic                          valid_s1;
	logic [gdpp_pkg::LUMA_W-1:0]   luma_s1;
	logic                          fs_s1;
	logic                          fire_s1;

	// packing state
	logic [gdpp_pkg::CARRY_W-1:0]  carry_q;
	logic [gdpp_pkg::BYTE_W-1:0]   partial_q;
	logic [gdpp_pkg::SLOT_W-1:0]   slot_q;

	// output register
	logic                          m_valid_q;
	logic [gdpp_pkg::BYTE_W-1:0]   m_data_q;

	// datapath
	logic [gdpp_pkg::CARRY_W-1:0]  mask;
	logic [3:0]                    bits;
	logic [3:0]                    count;
	logic [gdpp_pkg::CARRY_W-1:0]  carry_eff;
	logic [gdpp_pkg::BYTE_W-1:0]   partial_eff;
	logic [gdpp_pkg::SLOT_W-1:0]   slot_eff;
	logic signed [9:0]             sum;
	logic [gdpp_pkg::BYTE_W-1:0]   clamped;
	logic [gdpp_pkg::BYTE_W-1:0]   pix;
	logic [3:0]                    slot_end;
	logic [3:0]                    hi_pos;
	logic [2:0]                    pos;
	logic [gdpp_pkg::BYTE_W-1:0]   partial_new;
	logic [3:0]                    slot_next;
	logic                          emit;
	logic                          out_free;

	always_comb begin
		mask  = gdpp_pkg::dither_mask(cfg_q.bpp_log2);
		bits  = 4'd1 << cfg_q.bpp_log2;
		count = 4'd8 >> cfg_q.bpp_log2;

		// frame start reloads the remainder and restarts the byte; a slot left
		// out of range by a bpp change drops the partial byte
		carry_eff = fs_s1 ? (mask >> 1) : carry_q;
		if (fs_s1 || ({1'b0, slot_q} >= count)) begin
			partial_eff = '0;
			slot_eff    = '0;
		end else begin
			partial_eff = partial_q;
			slot_eff    = slot_q;
		end

		sum = $signed({2'b00, luma_s1})
		    + $signed({3'b000, (cfg_q.dither_enable ? carry_eff : 7'd0)})
		    + 10'(cfg_q.brightness)
		    - 10'(gdpp_pkg::BRIGHT_OFFSET);
		if (sum < 10'sd0)
			clamped = '0;
		else if (sum > 10'(gdpp_pkg::PIX_MAX))
			clamped = 8'(gdpp_pkg::PIX_MAX);
		else
			clamped = sum[7:0];

		pix = clamped >> (4'd8 - bits);

		// slot n sits at n*bits, or at 8-(n+1)*bits when first pixel goes high
		slot_end = ({1'b0, slot_eff} + 4'd1) << cfg_q.bpp_log2;
		hi_pos   = 4'd8 - slot_end;
		pos      = cfg_q.first_in_high_bits ? hi_pos[2:0] : 3'(slot_eff << cfg_q.bpp_log2);

		partial_new = partial_eff | 8'(pix << pos);
		slot_next   = {1'b0, slot_eff} + 4'd1;
		emit        = (slot_next == count);
	end

	assign out_free = !m_valid_q || m_tready;
	assign fire_s1  = valid_s1 && (out_free || !emit);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			luma_s1 <= s_tdata;
			fs_s1   <= s_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q   <= gdpp_pkg::dither_mask(gdpp_pkg::CFG_RESET.bpp_log2) >> 1;
			partial_q <= '0;
			slot_q    <= '0;
		end else if (fire_s1) begin
			carry_q <= cfg_q.dither_enable ? (clamped[gdpp_pkg::CARRY_W-1:0] & mask)
			                               : carry_eff;
			if (emit) begin
				partial_q <= '0;
				slot_q    <= '0;
			end else begin
				partial_q <= partial_new;
				slot_q    <= slot_next[gdpp_pkg::SLOT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit)
			m_data_q <= cfg_q.invert_output ? ~partial_new : partial_new;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// remainder is frozen while dithering is off and no frame starts
	a_carry_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !cfg_q.dither_enable && !fs_s1 |=> $stable(carry_q))
		else $error("carry changed with dithering off");

	// a completed byte always reaches the output register
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && emit |=> m_valid_q)
		else $error("completed byte not presented");

	// never overwrite an untaken byte
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && emit |-> !m_valid_q || m_tready)
		else $error("output byte overwritten");

	// a frame start that does not finish a byte leaves packing at slot 1
	a_fs_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && fs_s1 && !emit |=> slot_q == 3'd1)
		else $error("frame start did not restart packing");

	// input side only stalls behind a held word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && emit && m_valid_q && !m_tready)
		else $error("input stalled without cause");

endmodule

@@ tb/tb_gray_dither_pixel_packer.sv @@
`timescale 1ns / 100ps

// Tracks what the packer should emit: its own copy of the registers and of the
// carry / partial-byte / slot state, advanced once per accepted input word.
class gray_byte_tracker;
	logic [1:0]        bpp_log2;
	logic signed [7:0] brightness;
	bit                dither_on;
	bit                invert_on;
	bit                first_high;
	logic [6:0]        carry;
	logic [7:0]        partial;
	int                slot;
	logic [7:0]        bytes_due[$];
	int                errors;

	function new();
		bpp_log2   = 2'd2;
		brightness = '0;
		dither_on  = 1'b0;
		invert_on  = 1'b0;
		first_high = 1'b0;
		carry      = 7'(remainder_mask() >> 1);
		partial    = '0;
		slot       = 0;
		errors     = 0;
	endfunction

	// low (8 - bpp) bits of a clamped sample, capped at 7 bits
	function int remainder_mask();
		int bits;
		bits = 1 << bpp_log2;
		return ((1 << (8 - bits)) - 1) & 127;
	endfunction

	function void set_reg(gdpp_pkg::cfg_idx_t idx, logic [7:0] val);
		case (idx)
			gdpp_pkg::CFG_BPP_LOG2:   bpp_log2   = val[1:0];
			gdpp_pkg::CFG_BRIGHTNESS: brightness = val;
			gdpp_pkg::CFG_DITHER_EN:  dither_on  = val[0];
			gdpp_pkg::CFG_INVERT:     invert_on  = val[0];
			gdpp_pkg::CFG_FIRST_HIGH: first_high = val[0];
			default: ;
		endcase
	endfunction

	function void take_word(logic [7:0] luma, bit frame_start);
		int         bits;
		int         count;
		int         mask;
		int         level;
		int         pos;
		logic [7:0] pix;
		bits  = 1 << bpp_log2;
		count = 8 / bits;
		mask  = remainder_mask();
		if (frame_start) begin
			carry   = 7'(mask >> 1);
			partial = '0;
			slot    = 0;
		end
		// slot left over from a wider byte layout: drop the partial byte
		if (slot >= count) begin
			partial = '0;
			slot    = 0;
		end
		level = int'(luma);
		if (dither_on)
			level += int'(carry);
		level += int'(brightness) - gdpp_pkg::BRIGHT_OFFSET;
		if (level < 0)
			level = 0;
		else if (level > int'(gdpp_pkg::PIX_MAX))
			level = int'(gdpp_pkg::PIX_MAX);
		if (dither_on)
			carry = 7'(level & mask);
		pix     = 8'(level >> (8 - bits));
		pos     = first_high ? 8 - (slot + 1) * bits : slot * bits;
		partial = partial | 8'(pix << pos);
		slot    = (slot + 1) & 7;
		if (slot == 0 || slot >= count) begin
			bytes_due.push_back(invert_on ? ~partial : partial);
			partial = '0;
			slot    = 0;
		end
	endfunction

	function void match_byte(logic [7:0] got);
		logic [7:0] want;
		if (bytes_due.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("packed byte %02h with none outstanding", got);
			return;
		end
		want = bytes_due.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("packed byte mismatch: expected %02h, got %02h", want, got);
		end
	endfunction

	function int pending();
		return bytes_due.size();
	endfunction
endclass

module tb_gray_dither_pixel_packer;

	// settle time after the last expected byte: two-stage pipe plus margin
	localparam int DRAIN_CYCLES = 6;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata   = '0;     // luma[7:0]
	logic [0:0]          s_tuser   = '0;     // frame_start
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [7:0]          m_tdata;            // packed_byte[7:0]
	logic                cfg_we    = 1'b0;
	gdpp_pkg::cfg_idx_t  cfg_index = gdpp_pkg::CFG_BPP_LOG2;
	logic [7:0]          cfg_data  = '0;

	// percent of cycles each side holds off
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	gray_byte_tracker tracker = new();

	gray_dither_pixel_packer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// sink side: random backpressure at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitors read pre-edge values, same view the DUT samples
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			tracker.take_word(s_tdata, s_tuser[0]);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_byte(m_tdata);
	end

	// one word; each cycle before it is idle with the sender's idle odds
	task automatic send_word(input logic [7:0] luma, input bit frame_start);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= luma;
		s_tuser  <= frame_start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop sending, let every expected byte out, then let slot-only words settle
	task automatic drain_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input gdpp_pkg::cfg_idx_t idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	// block must be idle here; write enable stays high across the five writes
	task automatic program_regs(input logic [1:0] bpp, input logic [7:0] bright,
			input bit dither, input bit invert, input bit first_high);
		put_reg(gdpp_pkg::CFG_BPP_LOG2, {6'd0, bpp});
		put_reg(gdpp_pkg::CFG_BRIGHTNESS, bright);
		put_reg(gdpp_pkg::CFG_DITHER_EN, {7'd0, dither});
		put_reg(gdpp_pkg::CFG_INVERT, {7'd0, invert});
		put_reg(gdpp_pkg::CFG_FIRST_HIGH, {7'd0, first_high});
		cfg_we <= 1'b0;
	endtask

	// frames of random length led by a frame start; now and then a stray
	// frame start lands mid-frame. Halfway through, the sender holds until
	// the block has emitted everything owed.
	task automatic run_frames(input int n_words);
		int         left_in_frame;
		bit         fs;
		logic [7:0] luma;
		left_in_frame = 0;
		for (int i = 0; i < n_words; i++) begin
			if (i == n_words / 2)
				drain_block();
			fs = 1'b0;
			if (left_in_frame == 0) begin
				fs = 1'b1;
				left_in_frame = $urandom_range(1, 48);
			end else if ($urandom_range(0, 49) == 0) begin
				fs = 1'b1;
			end
			left_in_frame--;
			// lean on the clamp edges
			case ($urandom_range(0, 7))
				0:       luma = 8'h00;
				1:       luma = 8'hFF;
				2:       luma = 8'($urandom_range(0, 24));
				3:       luma = 8'($urandom_range(230, 255));
				default: luma = 8'($urandom);
			endcase
			send_word(luma, fs);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 78;

		// reset defaults (4bpp): black, white, mid-scale pair
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h7F, 1'b0);

		// 1bpp, max brightness, dither, inverted, first pixel high: a full
		// byte, then five pixels left pending in the byte
		drain_block();
		program_regs(2'd0, 8'h7F, 1'b1, 1'b1, 1'b1);
		send_word(8'h00, 1'b1);
		for (int i = 0; i < 12; i++)
			send_word(8'($urandom), 1'b0);

		// switch to 2bpp with slot 5 pending: partial byte is dropped, the
		// large 1bpp carry is added stale; min brightness
		drain_block();
		program_regs(2'd1, 8'h80, 1'b1, 1'b0, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h28, 1'b0);
		send_word(8'hC8, 1'b0);

		// 8bpp: empty dither mask, stale carry once, frame start mid-stream
		drain_block();
		program_regs(2'd3, 8'h00, 1'b1, 1'b1, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h10, 1'b0);
		send_word(8'hC8, 1'b1);

		// random settings, three idle profiles
		for (int s = 0; s < 12; s++) begin
			if (s == 4) begin
				send_idle_pct = 78;
				recv_idle_pct = 23;
			end else if (s == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain_block();
			program_regs(2'(s % 4),
				(s == 1) ? 8'h80 : (s == 6) ? 8'h7F : (s == 11) ? 8'h00 : 8'($urandom),
				(s % 3) != 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			run_frames(140);
		end

		drain_block();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
